@@ sv/confusion_matrix_f1_scorer_assert.svh @@
// Assertion macros shared by the confusion matrix scorer modules.
`ifndef CONFUSION_MATRIX_F1_SCORER_ASSERT_SVH
`define CONFUSION_MATRIX_F1_SCORER_ASSERT_SVH

// Same-cycle implication, checked on clk_i, off while rst_ni is low.
`define CMF1_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i, off while rst_ni is low.
`define CMF1_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/cmf1_pkg.sv @@
// Shared types, constants and helpers for the confusion matrix scorer.
package cmf1_pkg;

  localparam int COUNT_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 15;

  localparam int NUM_CLASSES = 5;
  localparam int CLASS_W     = 3;
  localparam int BASE_W      = 8;
  localparam int OP_W        = 2;
  localparam int PC_W        = 8;
  localparam int OUT_CNT_W   = 32;
  localparam int OUT_FRAC_W  = 16;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [PC_W-1:0] PC_RESET = 8'd1;

  localparam logic [BASE_W-1:0] CH_A = 8'h41;
  localparam logic [BASE_W-1:0] CH_C = 8'h43;
  localparam logic [BASE_W-1:0] CH_G = 8'h47;
  localparam logic [BASE_W-1:0] CH_T = 8'h54;

  typedef enum logic [OP_W-1:0] {
    OP_COUNT  = 2'd0,
    OP_REPORT = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  typedef enum logic [CLASS_W-1:0] {
    CLS_A     = 3'd0,
    CLS_C     = 3'd1,
    CLS_G     = 3'd2,
    CLS_T     = 3'd3,
    CLS_OTHER = 3'd4
  } cls_e;

  typedef struct packed {
    op_e  op;
    cls_e act;
    cls_e pred;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIVP,
    ST_DIVR,
    ST_MUL,
    ST_FGO,
    ST_DIVF,
    ST_EMIT
  } bk_state_e;

  function automatic cls_e base_class(input logic [BASE_W-1:0] b);
    cls_e c;
    unique case (b)
      CH_A:    c = CLS_A;
      CH_C:    c = CLS_C;
      CH_G:    c = CLS_G;
      CH_T:    c = CLS_T;
      default: c = CLS_OTHER;
    endcase
    return c;
  endfunction

endpackage

@@ sv/cmf1_front.sv @@
// Front stage: takes input words, decodes the opcode and classifies both bases.
module cmf1_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [cmf1_pkg::OP_W-1:0]   opcode_i,
  input  logic [cmf1_pkg::BASE_W-1:0] actual_base_i,
  input  logic [cmf1_pkg::BASE_W-1:0] predicted_base_i,
  input  logic                       q_full_i,
  output logic                       push_o,
  output cmf1_pkg::cmd_t             cmd_o
);
  import cmf1_pkg::*;

  logic v_q, v_d;
  logic take;
  logic known_op;
  cmd_t cmd_q, cmd_d;

  assign push_o     = v_q && !q_full_i;
  assign in_ready_o = !v_q || !q_full_i;
  assign take       = in_valid_i && in_ready_o;
  assign cmd_o      = cmd_q;

  always_comb begin
    cmd_d      = cmd_q;
    known_op   = 1'b1;
    cmd_d.act  = base_class(actual_base_i);
    cmd_d.pred = base_class(predicted_base_i);
    unique case (opcode_i)
      OP_COUNT:  cmd_d.op = OP_COUNT;
      OP_REPORT: cmd_d.op = OP_REPORT;
      OP_CLEAR:  cmd_d.op = OP_CLEAR;
      default:   known_op = 1'b0;  // unused opcode: word is dropped
    endcase
    if (take && known_op) begin
      v_d = 1'b1;
    end else if (push_o) begin
      v_d = 1'b0;
    end else begin
      v_d = v_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && known_op) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

@@ sv/cmf1_queue.sv @@
// Command queue between the front stage and the back end.
`include "confusion_matrix_f1_scorer_assert.svh"
module cmf1_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  cmf1_pkg::cmd_t data_i,
  output logic           full_o,
  output logic           valid_o,
  output cmf1_pkg::cmd_t data_o,
  input  logic           pop_i
);
  import cmf1_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  `CMF1_ASSERT_IMP(a_q_no_underflow, pop_i, cnt_q != '0, "queue popped while empty")
  `CMF1_ASSERT_IMP(a_q_no_overflow, push_i, cnt_q < CNT_W'(QUEUE_DEPTH), "queue pushed when full")
  `CMF1_ASSERT_NXT(a_q_cnt_inc, push_i && !pop_i, cnt_q == $past(cnt_q) + 1'b1, "queue count slip")

endmodule

@@ sv/cmf1_div.sv @@
// Restoring divider: one quotient bit per cycle, quotient known to fit QW bits.
module cmf1_div #(
  parameter int DW = 35,
  parameter int QW = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] rem0_i,
  input  logic [DW-1:0] den_i,
  input  logic [QW-1:0] low_i,
  output logic          done_o,
  output logic [QW-1:0] quot_o
);

  localparam int CW = $clog2(QW + 1);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] rem_q, den_q, rem_nxt;
  logic [QW-1:0] low_q, quot_q;
  logic          zero_q;
  logic [DW:0]   trial;
  logic          ge;

  // rem_q < den_q holds, so the shifted trial stays below twice the divisor
  assign trial   = {rem_q, low_q[QW-1]};
  assign ge      = (trial >= {1'b0, den_q});
  assign rem_nxt = ge ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
  assign done_o  = done_q;
  assign quot_o  = zero_q ? '0 : quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(QW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= rem0_i;
      den_q  <= den_i;
      low_q  <= low_i;
      zero_q <= (den_i == '0);
    end else if (busy_q) begin
      rem_q  <= rem_nxt;
      low_q  <= {low_q[QW-2:0], 1'b0};
      quot_q <= {quot_q[QW-2:0], ge};
    end
  end

endmodule

@@ sv/cmf1_back.sv @@
// Back end: confusion matrix, count and clear execution, report sequencer.
`include "confusion_matrix_f1_scorer_assert.svh"
module cmf1_back #(
  parameter int COUNT_WIDTH = cmf1_pkg::COUNT_WIDTH_DEF,
  parameter int FRAC_BITS   = cmf1_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [cmf1_pkg::PC_W-1:0]       pc_i,
  input  logic                           q_valid_i,
  input  cmf1_pkg::cmd_t                 q_cmd_i,
  output logic                           q_pop_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [cmf1_pkg::CLASS_W-1:0]    class_index_o,
  output logic [cmf1_pkg::OUT_CNT_W-1:0]  hit_count_o,
  output logic [cmf1_pkg::OUT_FRAC_W-1:0] precision_value_o,
  output logic [cmf1_pkg::OUT_FRAC_W-1:0] recall_value_o,
  output logic [cmf1_pkg::OUT_FRAC_W-1:0] f1_value_o,
  output logic [cmf1_pkg::OUT_CNT_W-1:0]  total_pairs_o,
  output logic                           last_o
);
  import cmf1_pkg::*;

  localparam int CW = COUNT_WIDTH;
  localparam int RW = CW + 3;               // row and column sums
  localparam int QW = FRAC_BITS + 1;        // ratios up to 1.0
  localparam int PW = 2 * QW + 1;           // 2*p*r
  localparam int DW = (RW > QW + 1) ? RW : QW + 1;
  localparam int HW = (CW > OUT_CNT_W) ? CW : OUT_CNT_W;
  localparam int VW = (QW > OUT_FRAC_W) ? QW : OUT_FRAC_W;
  localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};
  localparam logic [QW-1:0] Q_ONE   = QW'(1) << FRAC_BITS;
  localparam logic [HW-1:0] HIT_MAX = HW'({OUT_CNT_W{1'b1}});
  localparam logic [VW-1:0] VAL_MAX = VW'({OUT_FRAC_W{1'b1}});

  bk_state_e st_q, st_d;

  logic [PC_W-1:0]    pc_q;
  logic [CW-1:0]      cell_q [NUM_CLASSES][NUM_CLASSES];
  logic [RW-1:0]      rowsum_q [NUM_CLASSES];
  logic [RW-1:0]      colsum_q [NUM_CLASSES];
  logic [CW-1:0]      pair_q;
  logic [RW-1:0]      pc5;

  logic [CLASS_W-1:0] cls_q;
  logic [CW-1:0]      diag_rd, diag_q;
  logic [RW-1:0]      row_q;
  logic [QW-1:0]      pr_q, rc_q, f1_q;
  logic [PW-1:0]      prod_q;
  logic [QW:0]        psum;

  logic               do_count, do_clear, emit;
  logic               div_start, div_done;
  logic [DW-1:0]      div_rem0, div_den;
  logic [QW-1:0]      div_low, div_quot;

  logic               ov_q;
  logic [CLASS_W-1:0] o_cls_q;
  logic [OUT_CNT_W-1:0]  o_hit_q, o_tot_q;
  logic [OUT_FRAC_W-1:0] o_pr_q, o_rc_q, o_f1_q;
  logic               o_last_q;
  logic [HW-1:0]      hit_w, tot_w;
  logic [VW-1:0]      pr_w, rc_w, f1_w;

  assign pc5     = (RW'(pc_q) << 2) + RW'(pc_q);
  assign diag_rd = cell_q[cls_q][cls_q];
  assign psum    = {1'b0, pr_q} + {1'b0, rc_q};

  cmf1_div #(
    .DW(DW),
    .QW(QW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .rem0_i (div_rem0),
    .den_i  (div_den),
    .low_i  (div_low),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // Sequencer. The divider sees num*2^F with all but its low QW bits preloaded as
  // remainder, which is valid because every quotient here is at most 1.0.
  always_comb begin
    st_d      = st_q;
    q_pop_o   = 1'b0;
    do_count  = 1'b0;
    do_clear  = 1'b0;
    emit      = 1'b0;
    div_start = 1'b0;
    div_rem0  = '0;
    div_den   = '0;
    div_low   = '0;
    unique case (st_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          unique case (q_cmd_i.op)
            OP_COUNT:  do_count = 1'b1;
            OP_REPORT: st_d = ST_LOAD;
            OP_CLEAR:  do_clear = 1'b1;
            default:   st_d = ST_IDLE;
          endcase
        end
      end
      ST_LOAD: begin
        div_start = 1'b1;
        div_rem0  = DW'(diag_rd >> 1);
        div_low   = {diag_rd[0], {FRAC_BITS{1'b0}}};
        div_den   = DW'(colsum_q[cls_q]);
        st_d      = ST_DIVP;
      end
      ST_DIVP: begin
        if (div_done) begin
          div_start = 1'b1;
          div_rem0  = DW'(diag_q >> 1);
          div_low   = {diag_q[0], {FRAC_BITS{1'b0}}};
          div_den   = DW'(row_q);
          st_d      = ST_DIVR;
        end
      end
      ST_DIVR: begin
        if (div_done) begin
          st_d = ST_MUL;
        end
      end
      ST_MUL: st_d = ST_FGO;
      ST_FGO: begin
        div_start = 1'b1;
        div_rem0  = DW'(prod_q >> QW);
        div_low   = prod_q[QW-1:0];
        div_den   = DW'(psum);
        st_d      = ST_DIVF;
      end
      ST_DIVF: begin
        if (div_done) begin
          st_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!ov_q || out_ready_i) begin
          emit = 1'b1;
          st_d = (cls_q == CLASS_W'(CLS_OTHER)) ? ST_IDLE : ST_LOAD;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  // Matrix plus running row and column sums; sums move only when a cell moves
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= PC_RESET;
      pair_q <= '0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        rowsum_q[i] <= RW'(NUM_CLASSES) * RW'(PC_RESET);
        colsum_q[i] <= RW'(NUM_CLASSES) * RW'(PC_RESET);
        for (int j = 0; j < NUM_CLASSES; j++) begin
          cell_q[i][j] <= CW'(PC_RESET);
        end
      end
    end else begin
      if (cfg_we_i) begin
        pc_q <= pc_i;
      end
      if (do_clear) begin
        pair_q <= '0;
        for (int i = 0; i < NUM_CLASSES; i++) begin
          rowsum_q[i] <= pc5;
          colsum_q[i] <= pc5;
          for (int j = 0; j < NUM_CLASSES; j++) begin
            cell_q[i][j] <= CW'(pc_q);
          end
        end
      end else if (do_count) begin
        if (cell_q[q_cmd_i.act][q_cmd_i.pred] != CNT_MAX) begin
          cell_q[q_cmd_i.act][q_cmd_i.pred] <= cell_q[q_cmd_i.act][q_cmd_i.pred] + 1'b1;
          rowsum_q[q_cmd_i.act]  <= rowsum_q[q_cmd_i.act] + 1'b1;
          colsum_q[q_cmd_i.pred] <= colsum_q[q_cmd_i.pred] + 1'b1;
        end
        if (pair_q != CNT_MAX) begin
          pair_q <= pair_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cls_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      if (st_q == ST_IDLE) begin
        cls_q <= '0;
      end else if (emit) begin
        cls_q <= cls_q + 1'b1;
      end
      if (emit) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == ST_LOAD) begin
      diag_q <= diag_rd;
      row_q  <= rowsum_q[cls_q];
    end
    if (st_q == ST_DIVP && div_done) begin
      pr_q <= div_quot;
    end
    if (st_q == ST_DIVR && div_done) begin
      rc_q <= div_quot;
    end
    if (st_q == ST_MUL) begin
      prod_q <= (PW'(pr_q) * PW'(rc_q)) << 1;
    end
    if (st_q == ST_DIVF && div_done) begin
      f1_q <= div_quot;
    end
  end

  // Output clamps
  assign hit_w = HW'(diag_q);
  assign tot_w = HW'(pair_q);
  assign pr_w  = VW'(pr_q);
  assign rc_w  = VW'(rc_q);
  assign f1_w  = VW'(f1_q);

  always_ff @(posedge clk_i) begin
    if (emit) begin
      o_cls_q  <= cls_q;
      o_hit_q  <= (hit_w > HIT_MAX) ? {OUT_CNT_W{1'b1}} : hit_w[OUT_CNT_W-1:0];
      o_tot_q  <= (tot_w > HIT_MAX) ? {OUT_CNT_W{1'b1}} : tot_w[OUT_CNT_W-1:0];
      o_pr_q   <= (pr_w > VAL_MAX) ? {OUT_FRAC_W{1'b1}} : pr_w[OUT_FRAC_W-1:0];
      o_rc_q   <= (rc_w > VAL_MAX) ? {OUT_FRAC_W{1'b1}} : rc_w[OUT_FRAC_W-1:0];
      o_f1_q   <= (f1_w > VAL_MAX) ? {OUT_FRAC_W{1'b1}} : f1_w[OUT_FRAC_W-1:0];
      o_last_q <= (cls_q == CLASS_W'(CLS_OTHER));
    end
  end

  assign out_valid_o       = ov_q;
  assign class_index_o     = o_cls_q;
  assign hit_count_o       = o_hit_q;
  assign precision_value_o = o_pr_q;
  assign recall_value_o    = o_rc_q;
  assign f1_value_o        = o_f1_q;
  assign total_pairs_o     = o_tot_q;
  assign last_o            = o_last_q;

  `CMF1_ASSERT_IMP(a_row0_sum, 1'b1, rowsum_q[0] == RW'(cell_q[0][0]) + RW'(cell_q[0][1]) + RW'(cell_q[0][2]) + RW'(cell_q[0][3]) + RW'(cell_q[0][4]), "row sum out of step with cells")
  `CMF1_ASSERT_IMP(a_col0_sum, 1'b1, colsum_q[0] == RW'(cell_q[0][0]) + RW'(cell_q[1][0]) + RW'(cell_q[2][0]) + RW'(cell_q[3][0]) + RW'(cell_q[4][0]), "column sum out of step with cells")
  `CMF1_ASSERT_IMP(a_ratio_bound, div_done && (st_q == ST_DIVP || st_q == ST_DIVR), div_quot <= Q_ONE, "ratio above one")
  `CMF1_ASSERT_IMP(a_last_class, ov_q, o_last_q == (o_cls_q == CLASS_W'(CLS_OTHER)), "last flag on wrong class")

endmodule

@@ sv/confusion_matrix_f1_scorer.sv @@
// Top level of the confusion matrix precision, recall and F1 scorer.
// Each input word carries an opcode and two base bytes. Count (0) classifies
// actual and predicted bytes as A, C, G, T or other and bumps one cell of a
// 5x5 matrix plus the pair total, all saturating at 2^COUNT_WIDTH-1. Clear (2)
// reloads every cell with the pseudocount register and zeroes the pair total;
// reset does the same with a pseudocount of 1. Report (1) produces five
// result words, classes 0..4 in order, each with the diagonal count,
// precision (diagonal over column sum), recall (diagonal over row sum), F1
// and the pair total; ratios are unsigned with FRAC_BITS fraction bits,
// truncated, 0 on a zero denominator, and last marks the fifth word. Opcode 3
// is dropped. Timing: a front register and a 4-word queue feed the back end,
// which retires one count or clear word per cycle while no report runs. A
// report holds the back end until its fifth word is emitted; every class runs
// the one shared bit-serial divider three times (precision, recall, F1). While
// a report runs, up to five more words are still taken in. The pseudocount
// write port is always ready; writing it does not touch the matrix until
// the next clear.
module confusion_matrix_f1_scorer #(
  parameter int COUNT_WIDTH = cmf1_pkg::COUNT_WIDTH_DEF,  // 16..48
  parameter int FRAC_BITS   = cmf1_pkg::FRAC_BITS_DEF     // 8..30
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // pseudocount write port
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [cmf1_pkg::PC_W-1:0]       pseudocount_i,
  // input words
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [cmf1_pkg::OP_W-1:0]       opcode_i,
  input  logic [cmf1_pkg::BASE_W-1:0]     actual_base_i,
  input  logic [cmf1_pkg::BASE_W-1:0]     predicted_base_i,
  // result words
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [cmf1_pkg::CLASS_W-1:0]    class_index_o,
  output logic [cmf1_pkg::OUT_CNT_W-1:0]  hit_count_o,
  output logic [cmf1_pkg::OUT_FRAC_W-1:0] precision_value_o,
  output logic [cmf1_pkg::OUT_FRAC_W-1:0] recall_value_o,
  output logic [cmf1_pkg::OUT_FRAC_W-1:0] f1_value_o,
  output logic [cmf1_pkg::OUT_CNT_W-1:0]  total_pairs_o,
  output logic                           last_o
);
  import cmf1_pkg::*;

  logic push, q_full, q_valid, q_pop;
  cmd_t front_cmd, q_cmd;

  // Register write is a single 8-bit register, never stalls.
  assign cfg_ready_o = 1'b1;

  // Opcode decode and base classification, one word per cycle while the queue is not full.
  cmf1_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .opcode_i        (opcode_i),
    .actual_base_i   (actual_base_i),
    .predicted_base_i(predicted_base_i),
    .q_full_i        (q_full),
    .push_o          (push),
    .cmd_o           (front_cmd)
  );

  // Decouples the front from a back end busy with a report.
  cmf1_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (front_cmd),
    .full_o (q_full),
    .valid_o(q_valid),
    .data_o (q_cmd),
    .pop_i  (q_pop)
  );

  // Matrix, counters, divider and the result register.
  cmf1_back #(
    .COUNT_WIDTH(COUNT_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_valid_i),
    .pc_i             (pseudocount_i),
    .q_valid_i        (q_valid),
    .q_cmd_i          (q_cmd),
    .q_pop_o          (q_pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .class_index_o    (class_index_o),
    .hit_count_o      (hit_count_o),
    .precision_value_o(precision_value_o),
    .recall_value_o   (recall_value_o),
    .f1_value_o       (f1_value_o),
    .total_pairs_o    (total_pairs_o),
    .last_o           (last_o)
  );

endmodule
